### rtl/tsrd_pkg.sv
// shared types and constants for the tab-separated reply deframer
package tsrd_pkg;

    localparam longint unsigned MAX_FIELD_LEN_DEF = 64'd65535;
    localparam int unsigned     MAX_FIELDS_DEF    = 32'd255;

    localparam int RX_W    = 8;
    localparam int EVENT_W = 2;
    localparam int KIND_W  = 2;
    localparam int LEN_W   = 16;
    localparam int IDX_W   = 8;

    localparam logic [RX_W-1:0] CH_NUL     = 8'h00;
    localparam logic [RX_W-1:0] CH_ESC     = 8'h01;
    localparam logic [RX_W-1:0] CH_TAB     = 8'h09;
    localparam logic [RX_W-1:0] CH_NL      = 8'h0A;
    localparam logic [RX_W-1:0] CH_ESC_LO  = 8'h40;
    localparam logic [RX_W-1:0] CH_ESC_HI  = 8'h4F;
    localparam logic [RX_W-1:0] CH_DATA_LO = 8'd16;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 2'd0,
        EV_FIELD     = 2'd1,
        EV_FIELD_EOL = 2'd2,
        EV_ERROR     = 2'd3
    } t_event;

    typedef enum logic [KIND_W-1:0] {
        KIND_STRING  = 2'd0,
        KIND_ENCODED = 2'd1,
        KIND_NULL    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_NORMAL = 3'b001,
        ST_NULL   = 3'b010,
        ST_ESCAPE = 3'b100
    } t_state;

endpackage

### rtl/tab_separated_reply_deframer_core.sv
// tab-separated reply deframer: splits a reply byte stream into fields
//
// input channel: one reply byte per request on i_rx_byte, with i_in_valid and
// o_in_stall. output channel: one result per input byte on o_event_res,
// o_field_kind, o_field_length and o_field_index, with o_out_valid and
// i_out_stall. a result is 0 (none), 1 (field ended), 2 (field and reply
// ended) or 3 (error); kind, length and index are zero unless a field ended.
// each byte is decided in the cycle it is accepted and its result sits in the
// output register in the cycle after; throughput is one byte per cycle while
// the receiver does not stall.
// a new byte is taken while the previous result is being taken in the same
// cycle; o_in_stall rises only when a result is held and the receiver stalls,
// and the held result stays unchanged until it is taken.
// a malformed byte latches the error, and every later byte reports error.
// synchronous reset clears the parse state, counters, error and o_out_valid;
// the block takes requests from the first cycle after reset.
module tab_separated_reply_deframer_core #(
    parameter longint unsigned MAX_FIELD_LEN = tsrd_pkg::MAX_FIELD_LEN_DEF,
    parameter int unsigned     MAX_FIELDS    = tsrd_pkg::MAX_FIELDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tsrd_pkg::RX_W-1:0]    i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tsrd_pkg::EVENT_W-1:0] o_event_res,
    output logic [tsrd_pkg::KIND_W-1:0]  o_field_kind,
    output logic [tsrd_pkg::LEN_W-1:0]   o_field_length,
    output logic [tsrd_pkg::IDX_W-1:0]   o_field_index
);

    localparam int CNT_W = $clog2(MAX_FIELD_LEN + 64'd1);
    localparam int FC_W  = $clog2(MAX_FIELDS + 32'd1);
    localparam int CNT_X = (CNT_W > tsrd_pkg::LEN_W) ? CNT_W : tsrd_pkg::LEN_W;
    localparam int FC_X  = (FC_W > tsrd_pkg::IDX_W) ? FC_W : tsrd_pkg::IDX_W;

    tsrd_pkg::t_state r_state, n_state;
    logic             r_enc, n_enc;
    logic [CNT_W-1:0] r_len_cnt, n_len_cnt;
    logic [FC_W-1:0]  r_fld_cnt, n_fld_cnt;
    logic             r_err, n_err;

    logic                          r_out_valid;
    tsrd_pkg::t_event              r_event, n_event;
    tsrd_pkg::t_kind               r_kind, n_kind;
    logic [tsrd_pkg::LEN_W-1:0]    r_len, n_len;
    logic [tsrd_pkg::IDX_W-1:0]    r_idx, n_idx;

    logic                       in_fire;
    logic                       bad;
    logic                       fld_end;
    logic                       eol;
    tsrd_pkg::t_kind            end_kind;
    logic                       end_null;
    logic [CNT_X-1:0]           len_ext;
    logic [FC_X-1:0]            idx_ext;
    logic [tsrd_pkg::LEN_W-1:0] len_sat;
    logic [tsrd_pkg::IDX_W-1:0] idx_sat;
    logic [CNT_W-1:0]           len_inc;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_fire    = i_in_valid && !o_in_stall;

    // counters clip to the port widths on the way out
    assign len_ext = CNT_X'(r_len_cnt);
    assign idx_ext = FC_X'(r_fld_cnt);
    assign len_sat = (len_ext > CNT_X'(16'hFFFF)) ? 16'hFFFF : len_ext[tsrd_pkg::LEN_W-1:0];
    assign idx_sat = (idx_ext > FC_X'(8'hFF)) ? 8'hFF : idx_ext[tsrd_pkg::IDX_W-1:0];
    assign len_inc = (r_len_cnt < CNT_W'(MAX_FIELD_LEN)) ? r_len_cnt + CNT_W'(1) : r_len_cnt;

    always_comb begin
        n_state   = r_state;
        n_enc     = r_enc;
        n_len_cnt = r_len_cnt;
        n_fld_cnt = r_fld_cnt;
        n_err     = r_err;
        n_event   = tsrd_pkg::EV_NONE;
        n_kind    = tsrd_pkg::KIND_STRING;
        n_len     = '0;
        n_idx     = '0;
        bad       = 1'b0;
        fld_end   = 1'b0;
        end_null  = 1'b0;
        eol       = (i_rx_byte == tsrd_pkg::CH_NL);
        end_kind  = r_enc ? tsrd_pkg::KIND_ENCODED : tsrd_pkg::KIND_STRING;

        if (r_err) begin
            n_event = tsrd_pkg::EV_ERROR;
        end else begin
            unique case (r_state)
                tsrd_pkg::ST_NORMAL: begin
                    if (i_rx_byte >= tsrd_pkg::CH_DATA_LO) begin
                        n_len_cnt = len_inc;
                    end else if (i_rx_byte == tsrd_pkg::CH_TAB || eol) begin
                        fld_end = 1'b1;
                    end else if (i_rx_byte == tsrd_pkg::CH_NUL) begin
                        n_state = tsrd_pkg::ST_NULL;
                    end else if (i_rx_byte == tsrd_pkg::CH_ESC) begin
                        n_len_cnt = len_inc;
                        n_enc     = 1'b1;
                        n_state   = tsrd_pkg::ST_ESCAPE;
                    end else begin
                        bad = 1'b1;
                    end
                end
                tsrd_pkg::ST_NULL: begin
                    if (i_rx_byte == tsrd_pkg::CH_TAB || eol) begin
                        fld_end  = 1'b1;
                        end_null = 1'b1;
                        end_kind = tsrd_pkg::KIND_NULL;
                    end else begin
                        bad = 1'b1;
                    end
                end
                tsrd_pkg::ST_ESCAPE: begin
                    if (i_rx_byte >= tsrd_pkg::CH_ESC_LO && i_rx_byte <= tsrd_pkg::CH_ESC_HI) begin
                        n_len_cnt = len_inc;
                        n_state   = tsrd_pkg::ST_NORMAL;
                    end else begin
                        bad = 1'b1;
                    end
                end
                default: begin
                    bad = 1'b1;
                end
            endcase

            if (fld_end) begin
                n_event = eol ? tsrd_pkg::EV_FIELD_EOL : tsrd_pkg::EV_FIELD;
                n_kind  = end_kind;
                n_len   = end_null ? '0 : len_sat;
                n_idx   = idx_sat;
                if (eol) begin
                    n_fld_cnt = '0;
                end else if (r_fld_cnt < FC_W'(MAX_FIELDS)) begin
                    n_fld_cnt = r_fld_cnt + FC_W'(1);
                end
                n_len_cnt = '0;
                n_enc     = 1'b0;
                n_state   = tsrd_pkg::ST_NORMAL;
            end

            if (bad) begin
                n_err   = 1'b1;
                n_event = tsrd_pkg::EV_ERROR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsrd_pkg::ST_NORMAL;
            r_enc       <= 1'b0;
            r_len_cnt   <= '0;
            r_fld_cnt   <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state   <= n_state;
                r_enc     <= n_enc;
                r_len_cnt <= n_len_cnt;
                r_fld_cnt <= n_fld_cnt;
                r_err     <= n_err;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only when a byte is taken
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_event <= n_event;
            r_kind  <= n_kind;
            r_len   <= n_len;
            r_idx   <= n_idx;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_event;
    assign o_field_kind   = r_kind;
    assign o_field_length = r_len;
    assign o_field_index  = r_idx;

`ifndef SYNTH
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("error flag cleared without reset");

    a_err_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_err) |=> (o_event_res == tsrd_pkg::EV_ERROR))
        else $error("byte after error not reported as error");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == tsrd_pkg::EV_NONE ||
                         o_event_res == tsrd_pkg::EV_ERROR))
        |-> (o_field_length == '0 && o_field_index == '0 &&
             o_field_kind == tsrd_pkg::KIND_STRING))
        else $error("field data on a result with no ended field");

    a_null_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_field_kind == tsrd_pkg::KIND_NULL) |-> (o_field_length == '0))
        else $error("null field with nonzero length");

    a_enc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !r_err && fld_end) |=> !r_enc)
        else $error("encoded flag survives end of field");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// testbench for the reply deframer: directed, saturating, backpressure, random and error replies
module tb_top;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_BYTES = 1000;
    localparam int LONG_FIELD   = 300;
    localparam int LONG_HOLD    = 200;

    typedef struct packed {
        tsrd_pkg::t_event           ev;
        tsrd_pkg::t_kind            kind;
        logic [tsrd_pkg::LEN_W-1:0] len;
        logic [tsrd_pkg::IDX_W-1:0] idx;
    } t_field_event;

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic [tsrd_pkg::RX_W-1:0]    rx_byte   = '0;
    logic                         out_stall = 1'b0;
    wire                          in_stall;
    wire                          out_valid;
    wire [tsrd_pkg::EVENT_W-1:0]  ev_res;
    wire [tsrd_pkg::KIND_W-1:0]   fld_kind;
    wire [tsrd_pkg::LEN_W-1:0]    fld_len;
    wire [tsrd_pkg::IDX_W-1:0]    fld_idx;

    // parser mirror, starts in its reset state
    tsrd_pkg::t_state             pstate   = tsrd_pkg::ST_NORMAL;
    bit                           enc_seen = 1'b0;
    bit                           err_seen = 1'b0;
    logic [tsrd_pkg::LEN_W-1:0]   len_cnt  = '0;
    logic [tsrd_pkg::IDX_W-1:0]   fld_cnt  = '0;
    t_field_event                 field_events_q [$];

    int                  cycle_cnt    = 0;
    int                  mismatch_cnt = 0;
    int                  bytes_sent   = 0;
    bit                  in_quiet     = 1'b0;
    bit                  out_quiet    = 1'b0;
    bit                  hold_req     = 1'b0;

    tab_separated_reply_deframer_core u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_event_res    (ev_res),
        .o_field_kind   (fld_kind),
        .o_field_length (fld_len),
        .o_field_index  (fld_idx)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void bump_len();
        if (len_cnt < tsrd_pkg::MAX_FIELD_LEN_DEF)
            len_cnt++;
    endfunction

    function automatic t_field_event close_field(input bit eol, input tsrd_pkg::t_kind k,
                                                 input logic [tsrd_pkg::LEN_W-1:0] flen);
        t_field_event r;
        r = '0;
        if (eol)
            r.ev = tsrd_pkg::EV_FIELD_EOL;
        else
            r.ev = tsrd_pkg::EV_FIELD;
        r.kind = k;
        r.len  = flen;
        r.idx  = fld_cnt;
        if (eol)
            fld_cnt = '0;
        else if (fld_cnt < tsrd_pkg::MAX_FIELDS_DEF)
            fld_cnt++;
        len_cnt  = '0;
        enc_seen = 1'b0;
        pstate   = tsrd_pkg::ST_NORMAL;
        return r;
    endfunction

    // expected event for one accepted reply byte
    function automatic void decode_byte(input logic [tsrd_pkg::RX_W-1:0] b);
        t_field_event r;
        r = '0;
        if (!err_seen) begin
            case (pstate)
                tsrd_pkg::ST_NORMAL: begin
                    if (b >= tsrd_pkg::CH_DATA_LO) begin
                        bump_len();
                    end else if (b == tsrd_pkg::CH_TAB || b == tsrd_pkg::CH_NL) begin
                        if (enc_seen)
                            r = close_field(b == tsrd_pkg::CH_NL, tsrd_pkg::KIND_ENCODED,
                                            len_cnt);
                        else
                            r = close_field(b == tsrd_pkg::CH_NL, tsrd_pkg::KIND_STRING,
                                            len_cnt);
                    end else if (b == tsrd_pkg::CH_NUL) begin
                        pstate = tsrd_pkg::ST_NULL;
                    end else if (b == tsrd_pkg::CH_ESC) begin
                        bump_len();
                        enc_seen = 1'b1;
                        pstate   = tsrd_pkg::ST_ESCAPE;
                    end else begin
                        err_seen = 1'b1;
                    end
                end
                tsrd_pkg::ST_NULL: begin
                    if (b == tsrd_pkg::CH_TAB || b == tsrd_pkg::CH_NL)
                        r = close_field(b == tsrd_pkg::CH_NL, tsrd_pkg::KIND_NULL, '0);
                    else
                        err_seen = 1'b1;
                end
                tsrd_pkg::ST_ESCAPE: begin
                    if (b >= tsrd_pkg::CH_ESC_LO && b <= tsrd_pkg::CH_ESC_HI) begin
                        bump_len();
                        pstate = tsrd_pkg::ST_NORMAL;
                    end else begin
                        err_seen = 1'b1;
                    end
                end
                default: err_seen = 1'b1;
            endcase
        end
        if (err_seen) begin
            r    = '0;
            r.ev = tsrd_pkg::EV_ERROR;
        end
        field_events_q.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [tsrd_pkg::LEN_W-1:0] got,
                                   input logic [tsrd_pkg::LEN_W-1:0] want);
        mismatch_cnt++;
        $display("cycle %0d: %s mismatch, got %0h expected %0h",
                 cycle_cnt, what, got, want);
    endtask

    task automatic send_byte(input logic [tsrd_pkg::RX_W-1:0] b);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        decode_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [tsrd_pkg::RX_W-1:0] rand_data_byte();
        case ($urandom_range(0, 9))
            0:       return tsrd_pkg::CH_DATA_LO;
            1:       return 8'hFF;
            default: return tsrd_pkg::RX_W'($urandom_range(tsrd_pkg::CH_DATA_LO, 255));
        endcase
    endfunction

    task automatic send_escape_pair();
        send_byte(tsrd_pkg::CH_ESC);
        send_byte(tsrd_pkg::CH_ESC_LO + tsrd_pkg::RX_W'($urandom_range(0, 15)));
    endtask

    // one well-formed reply with random field kinds and contents
    task automatic send_reply(input int n_fields);
        int flen;
        for (int k = 0; k < n_fields; k++) begin
            flen = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
            case ($urandom_range(0, 3))
                2: begin
                    for (int j = 0; j < flen; j++) begin
                        if ($urandom_range(0, 1))
                            send_escape_pair();
                        else
                            send_byte(rand_data_byte());
                    end
                end
                3: begin
                    // anything before the null marker is dropped
                    for (int j = 0; j < flen % 3; j++) begin
                        if ($urandom_range(0, 1))
                            send_escape_pair();
                        else
                            send_byte(rand_data_byte());
                    end
                    send_byte(tsrd_pkg::CH_NUL);
                end
                default: begin
                    for (int j = 0; j < flen; j++)
                        send_byte(rand_data_byte());
                end
            endcase
            send_byte((k == n_fields - 1) ? tsrd_pkg::CH_NL : tsrd_pkg::CH_TAB);
        end
    endtask

    task automatic test_directed_fields();
        logic [tsrd_pkg::RX_W-1:0] seq [$] = '{
            tsrd_pkg::CH_DATA_LO, 8'hFF, tsrd_pkg::CH_TAB,
            tsrd_pkg::CH_ESC, tsrd_pkg::CH_ESC_LO, 8'h7F, tsrd_pkg::CH_TAB,
            tsrd_pkg::CH_ESC, tsrd_pkg::CH_ESC_HI, tsrd_pkg::CH_NL,
            tsrd_pkg::CH_NL,
            tsrd_pkg::CH_NUL, tsrd_pkg::CH_TAB,
            8'h20, tsrd_pkg::CH_ESC, 8'h45, tsrd_pkg::CH_NUL, tsrd_pkg::CH_TAB,
            8'h41, tsrd_pkg::CH_NL,
            tsrd_pkg::CH_TAB, tsrd_pkg::CH_NUL, tsrd_pkg::CH_NL
        };
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_field_index_saturation();
        in_quiet  = 1'b1;
        out_quiet = 1'b1;
        for (int k = 0; k < 300; k++) begin
            if (k % 7 == 0)
                send_byte(rand_data_byte());
            send_byte(tsrd_pkg::CH_TAB);
        end
        send_byte(tsrd_pkg::CH_NL);
        // index starts over in the next reply
        send_byte(8'h30);
        send_byte(tsrd_pkg::CH_TAB);
        send_byte(tsrd_pkg::CH_NL);
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    task automatic test_long_field();
        in_quiet  = 1'b1;
        out_quiet = 1'b1;
        send_escape_pair();
        for (int k = 0; k < LONG_FIELD; k++)
            send_byte(rand_data_byte());
        send_byte(tsrd_pkg::CH_TAB);
        for (int k = 0; k < 3; k++)
            send_byte(rand_data_byte());
        send_byte(tsrd_pkg::CH_NL);
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    task automatic test_input_backpressure();
        int stop_at;
        stop_at  = bytes_sent + 60;
        in_quiet = 1'b1;
        hold_req = 1'b1;
        while (bytes_sent < stop_at)
            send_reply($urandom_range(1, 4));
        in_quiet = 1'b0;
    endtask

    task automatic test_random_replies();
        int stop_at;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            in_quiet  = ($urandom_range(0, 4) == 0);
            out_quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                send_reply($urandom_range(7, 20));
            else
                send_reply($urandom_range(1, 5));
        end
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    // error is sticky and reset is never repeated, so only one kind per run
    task automatic test_sticky_error();
        logic [tsrd_pkg::RX_W-1:0] b;
        send_byte(rand_data_byte());
        send_byte(tsrd_pkg::CH_TAB);
        case ($urandom_range(0, 2))
            0: begin
                b = tsrd_pkg::RX_W'($urandom_range(2, 13));
                if (b > tsrd_pkg::CH_ESC + 7)
                    b = b + 8'd2;
                send_byte(b);
            end
            1: begin
                do b = tsrd_pkg::RX_W'($urandom_range(0, 255));
                while (b == tsrd_pkg::CH_TAB || b == tsrd_pkg::CH_NL);
                send_byte(tsrd_pkg::CH_NUL);
                send_byte(b);
            end
            default: begin
                do b = tsrd_pkg::RX_W'($urandom_range(0, 255));
                while (b >= tsrd_pkg::CH_ESC_LO && b <= tsrd_pkg::CH_ESC_HI);
                send_byte(tsrd_pkg::CH_ESC);
                send_byte(b);
            end
        endcase
        for (int k = 0; k < 40; k++)
            send_byte(tsrd_pkg::RX_W'($urandom_range(0, 255)));
    endtask

    task automatic check_field_event();
        t_field_event exp;
        if (field_events_q.size() == 0) begin
            report_mismatch("unrequested result event", ev_res, '0);
        end else begin
            exp = field_events_q.pop_front();
            if (ev_res !== exp.ev)
                report_mismatch("event", ev_res, exp.ev);
            if (fld_kind !== exp.kind)
                report_mismatch("field kind", fld_kind, exp.kind);
            if (fld_len !== exp.len)
                report_mismatch("field length", fld_len, exp.len);
            if (fld_idx !== exp.idx)
                report_mismatch("field index", fld_idx, exp.idx);
        end
    endtask

    initial begin : result_sink
        int n;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                n        = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                n = out_quiet ? 0 : $urandom_range(0, 12);
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            check_field_event();
        end
    end

    initial begin : test_sequence
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_fields();
        test_field_index_saturation();
        test_long_field();
        test_input_backpressure();
        test_random_replies();
        test_sticky_error();
        in_valid <= 1'b0;
        while (field_events_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/tsrd_pkg.sv
rtl/tab_separated_reply_deframer_core.sv
tb/tb_top.sv
